// File: src/cws_pkg.sv
// Shared types, constants and pointer helpers for the circular window sum block.
package cws_pkg;

    // Store depth and derived widths
    localparam int MAX_LENGTH = 64;
    localparam int ADDR_W     = $clog2(MAX_LENGTH);

    // Field widths
    localparam int SAMPLE_W = 16;
    localparam int TOTAL_W  = 22;
    localparam int WIN_W    = 7;
    localparam int LEN_W    = WIN_W - 1;

    // Most negative window code is folded onto the next value up
    localparam logic [WIN_W-1:0] WIN_MOST_NEG = {1'b1, {(WIN_W-1){1'b0}}};
    localparam logic [WIN_W-1:0] WIN_CLAMP    = WIN_MOST_NEG + WIN_W'(1);

    // Sequencer states
    typedef enum logic [2:0] {
        ST_LOAD,
        ST_START,
        ST_ACC_RD,
        ST_ACC_ADD,
        ST_EMIT,
        ST_SLIDE_RD,
        ST_SLIDE_ADD
    } t_state;

    // Accumulator controls from the sequencer
    typedef struct packed {
        logic clear;
        logic add;
        logic use_sub;
    } t_acc_ctrl;

    // Step a ring pointer forward, wrapping after the last index
    function automatic logic [ADDR_W-1:0] ptr_inc(input logic [ADDR_W-1:0] ptr,
                                                  input logic [ADDR_W-1:0] last);
        logic [ADDR_W-1:0] res;
        res = (ptr == last) ? '0 : ptr + ADDR_W'(1);
        return res;
    endfunction

    // Step a ring pointer backward, wrapping to the last index
    function automatic logic [ADDR_W-1:0] ptr_dec(input logic [ADDR_W-1:0] ptr,
                                                  input logic [ADDR_W-1:0] last);
        logic [ADDR_W-1:0] res;
        res = (ptr == '0) ? last : ptr - ADDR_W'(1);
        return res;
    endfunction

endpackage

// File: src/cws_store.sv
// Sample memory: one write port, two registered read ports.
module cws_store (
    input  logic                                  i_clk,
    input  logic                                  i_wr_en,
    input  logic [cws_pkg::ADDR_W-1:0]            i_wr_addr,
    input  logic signed [cws_pkg::SAMPLE_W-1:0]   i_wr_data,
    input  logic [cws_pkg::ADDR_W-1:0]            i_rd_addr_a,
    input  logic [cws_pkg::ADDR_W-1:0]            i_rd_addr_b,
    output logic signed [cws_pkg::SAMPLE_W-1:0]   o_rd_data_a,
    output logic signed [cws_pkg::SAMPLE_W-1:0]   o_rd_data_b
);

    logic signed [cws_pkg::SAMPLE_W-1:0] r_mem [cws_pkg::MAX_LENGTH];
    logic signed [cws_pkg::SAMPLE_W-1:0] r_rd_a;
    logic signed [cws_pkg::SAMPLE_W-1:0] r_rd_b;

    // Write incoming samples
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read both ports every cycle
    always_ff @(posedge i_clk) begin
        r_rd_a <= r_mem[i_rd_addr_a];
        r_rd_b <= r_mem[i_rd_addr_b];
    end

    assign o_rd_data_a = r_rd_a;
    assign o_rd_data_b = r_rd_b;

endmodule

// File: src/cws_accum.sv
// Shared add/subtract unit and the running window total.
module cws_accum (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  cws_pkg::t_acc_ctrl                    i_ctrl,
    input  logic signed [cws_pkg::SAMPLE_W-1:0]   i_add_data,
    input  logic signed [cws_pkg::SAMPLE_W-1:0]   i_sub_data,
    output logic signed [cws_pkg::TOTAL_W-1:0]    o_total
);

    localparam int EXT_W = cws_pkg::TOTAL_W - cws_pkg::SAMPLE_W;

    logic signed [cws_pkg::TOTAL_W-1:0] r_total;
    logic signed [cws_pkg::TOTAL_W-1:0] n_total;
    logic signed [cws_pkg::TOTAL_W-1:0] add_ext;
    logic signed [cws_pkg::TOTAL_W-1:0] sub_ext;

    // Sign-extend operands; drop the subtrahend while accumulating
    always_comb begin
        add_ext = {{EXT_W{i_add_data[cws_pkg::SAMPLE_W-1]}}, i_add_data};
        sub_ext = i_ctrl.use_sub ? {{EXT_W{i_sub_data[cws_pkg::SAMPLE_W-1]}}, i_sub_data}
                                 : '0;
        n_total = r_total + add_ext - sub_ext;
    end

    // Hold, clear or advance the total
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= '0;
        end else if (i_ctrl.clear) begin
            r_total <= '0;
        end else if (i_ctrl.add) begin
            r_total <= n_total;
        end
    end

    assign o_total = r_total;

endmodule

// File: src/cws_seq.sv
// Sequencer: loads samples, walks the first window, then slides and emits each sum.
module cws_seq (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    input  logic                                  i_final_sample,
    output logic                                  o_in_stall,
    input  logic signed [cws_pkg::WIN_W-1:0]      i_window,
    output logic                                  o_wr_en,
    output logic [cws_pkg::ADDR_W-1:0]            o_wr_addr,
    output logic [cws_pkg::ADDR_W-1:0]            o_rd_addr_a,
    output logic [cws_pkg::ADDR_W-1:0]            o_rd_addr_b,
    output cws_pkg::t_acc_ctrl                    o_acc_ctrl,
    output logic                                  o_out_valid,
    output logic                                  o_final_total,
    input  logic                                  i_out_stall
);

    cws_pkg::t_state r_state;
    cws_pkg::t_state n_state;

    logic [cws_pkg::ADDR_W-1:0] r_count;
    logic [cws_pkg::ADDR_W-1:0] r_last_idx;
    logic [cws_pkg::ADDR_W-1:0] r_pos;
    logic [cws_pkg::ADDR_W-1:0] r_walk;
    logic [cws_pkg::ADDR_W-1:0] r_add_ptr;
    logic [cws_pkg::ADDR_W-1:0] r_sub_ptr;
    logic [cws_pkg::LEN_W-1:0]  r_steps;
    logic                       r_neg;

    logic                       in_beat;
    logic                       out_beat;
    logic                       run_end;
    logic                       last_pos;
    logic [cws_pkg::WIN_W-1:0]  win_abs;
    logic [cws_pkg::LEN_W-1:0]  win_len;
    logic                       win_zero;

    // Handshake and run bookkeeping
    assign in_beat  = i_in_valid && !o_in_stall;
    assign out_beat = o_out_valid && !i_out_stall;
    assign run_end  = i_final_sample || (r_count == cws_pkg::ADDR_W'(cws_pkg::MAX_LENGTH - 1));
    assign last_pos = (r_pos == r_last_idx);

    // Window magnitude
    assign win_abs  = i_window[cws_pkg::WIN_W-1] ? -i_window : i_window;
    assign win_len  = win_abs[cws_pkg::LEN_W-1:0];
    assign win_zero = (i_window == '0);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            cws_pkg::ST_LOAD: begin
                if (in_beat && run_end) begin
                    n_state = cws_pkg::ST_START;
                end
            end
            cws_pkg::ST_START: begin
                n_state = win_zero ? cws_pkg::ST_EMIT : cws_pkg::ST_ACC_RD;
            end
            cws_pkg::ST_ACC_RD: begin
                n_state = cws_pkg::ST_ACC_ADD;
            end
            cws_pkg::ST_ACC_ADD: begin
                n_state = (r_steps == '0) ? cws_pkg::ST_EMIT : cws_pkg::ST_ACC_RD;
            end
            cws_pkg::ST_EMIT: begin
                if (out_beat) begin
                    n_state = last_pos ? cws_pkg::ST_LOAD : cws_pkg::ST_SLIDE_RD;
                end
            end
            cws_pkg::ST_SLIDE_RD: begin
                n_state = cws_pkg::ST_SLIDE_ADD;
            end
            cws_pkg::ST_SLIDE_ADD: begin
                n_state = cws_pkg::ST_EMIT;
            end
            default: begin
                n_state = cws_pkg::ST_LOAD;
            end
        endcase
    end

    // Outputs
    always_comb begin
        o_in_stall         = (r_state != cws_pkg::ST_LOAD);
        o_out_valid        = (r_state == cws_pkg::ST_EMIT);
        o_final_total      = last_pos;
        o_wr_en            = in_beat;
        o_wr_addr          = r_count;
        o_rd_addr_a        = (r_state == cws_pkg::ST_ACC_RD) ? r_walk : r_add_ptr;
        o_rd_addr_b        = r_sub_ptr;
        o_acc_ctrl.clear   = (r_state == cws_pkg::ST_START);
        o_acc_ctrl.add     = (r_state == cws_pkg::ST_ACC_ADD) ||
                             (r_state == cws_pkg::ST_SLIDE_ADD);
        o_acc_ctrl.use_sub = (r_state == cws_pkg::ST_SLIDE_ADD);
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cws_pkg::ST_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    // Fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (in_beat) begin
            r_count <= run_end ? '0 : r_count + cws_pkg::ADDR_W'(1);
        end
    end

    // Ring pointers and step counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_idx <= '0;
            r_pos      <= '0;
            r_walk     <= '0;
            r_add_ptr  <= '0;
            r_sub_ptr  <= '0;
            r_steps    <= '0;
            r_neg      <= 1'b0;
        end else begin
            unique case (r_state)
                cws_pkg::ST_LOAD: begin
                    if (in_beat && run_end) begin
                        r_last_idx <= r_count;
                    end
                end
                cws_pkg::ST_START: begin
                    // Positive walks forward from one, negative backward from the end
                    r_pos     <= '0;
                    r_steps   <= win_len;
                    r_neg     <= i_window[cws_pkg::WIN_W-1];
                    r_walk    <= i_window[cws_pkg::WIN_W-1] ? r_last_idx
                                                            : cws_pkg::ptr_inc('0, r_last_idx);
                    r_add_ptr <= '0;
                    r_sub_ptr <= '0;
                end
                cws_pkg::ST_ACC_RD: begin
                    r_walk  <= r_neg ? cws_pkg::ptr_dec(r_walk, r_last_idx)
                                     : cws_pkg::ptr_inc(r_walk, r_last_idx);
                    r_steps <= r_steps - cws_pkg::LEN_W'(1);
                end
                cws_pkg::ST_ACC_ADD: begin
                    // Set the slide pointers once the first window is summed
                    if (r_steps == '0) begin
                        if (r_neg) begin
                            r_add_ptr <= '0;
                            r_sub_ptr <= cws_pkg::ptr_inc(r_walk, r_last_idx);
                        end else begin
                            r_add_ptr <= r_walk;
                            r_sub_ptr <= cws_pkg::ptr_inc('0, r_last_idx);
                        end
                    end
                end
                cws_pkg::ST_EMIT: begin
                    if (out_beat && !last_pos) begin
                        r_pos <= r_pos + cws_pkg::ADDR_W'(1);
                    end
                end
                cws_pkg::ST_SLIDE_RD: begin
                    r_steps <= r_steps;
                end
                cws_pkg::ST_SLIDE_ADD: begin
                    r_add_ptr <= cws_pkg::ptr_inc(r_add_ptr, r_last_idx);
                    r_sub_ptr <= cws_pkg::ptr_inc(r_sub_ptr, r_last_idx);
                end
                default: begin
                    r_steps <= r_steps;
                end
            endcase
        end
    end

    // A result is never offered while samples are taken
    a_emit_blocks_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("result offered while input open");

    // Output index stays inside the run
    a_pos_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (r_pos <= r_last_idx))
        else $error("output index beyond run");

    // The last sum of a run reopens the input
    a_reopen_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_beat && o_final_total) |=> !o_in_stall)
        else $error("input not reopened after last sum");

    // A walk read always has a step left
    a_walk_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == cws_pkg::ST_ACC_RD) |-> (r_steps != '0))
        else $error("walk read with no steps left");

endmodule

// File: src/circular_window_sum.sv
// Top level of the circular window sum block: window register and unit wiring.
// A sample that does not end a run is taken while the input is open; the final sample is
// followed by a setup state and a walk read and add for each window step summing the
// first window, then the first sum is offered. Each further sum is offered after a slide
// read and a slide add once the previous is taken; sums come from one shared adder
// and the two-port sample memory. The input reopens the cycle after the last run sum is
// taken. Reset clears the sequencer, fill count, total and window (to 0), not the memory.
module circular_window_sum (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic signed [cws_pkg::SAMPLE_W-1:0]   i_sample,
    input  logic                                  i_final_sample,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic signed [cws_pkg::TOTAL_W-1:0]    o_window_total,
    output logic                                  o_final_total,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic signed [cws_pkg::WIN_W-1:0]      i_cfg_window
);

    logic signed [cws_pkg::WIN_W-1:0]    r_window;
    logic [cws_pkg::ADDR_W-1:0]          wr_addr;
    logic [cws_pkg::ADDR_W-1:0]          rd_addr_a;
    logic [cws_pkg::ADDR_W-1:0]          rd_addr_b;
    logic signed [cws_pkg::SAMPLE_W-1:0] rd_data_a;
    logic signed [cws_pkg::SAMPLE_W-1:0] rd_data_b;
    logic                                wr_en;
    cws_pkg::t_acc_ctrl                  acc_ctrl;

    assign o_cfg_ready = 1'b1;

    // Window register; fold the most negative code onto its neighbor
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_window <= (i_cfg_window == cws_pkg::WIN_MOST_NEG) ? cws_pkg::WIN_CLAMP
                                                                : i_cfg_window;
        end
    end

    cws_seq u_seq (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_final_sample (i_final_sample),
        .o_in_stall     (o_in_stall),
        .i_window       (r_window),
        .o_wr_en        (wr_en),
        .o_wr_addr      (wr_addr),
        .o_rd_addr_a    (rd_addr_a),
        .o_rd_addr_b    (rd_addr_b),
        .o_acc_ctrl     (acc_ctrl),
        .o_out_valid    (o_out_valid),
        .o_final_total  (o_final_total),
        .i_out_stall    (i_out_stall)
    );

    cws_store u_store (
        .i_clk       (i_clk),
        .i_wr_en     (wr_en),
        .i_wr_addr   (wr_addr),
        .i_wr_data   (i_sample),
        .i_rd_addr_a (rd_addr_a),
        .i_rd_addr_b (rd_addr_b),
        .o_rd_data_a (rd_data_a),
        .o_rd_data_b (rd_data_b)
    );

    cws_accum u_accum (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctrl     (acc_ctrl),
        .i_add_data (rd_data_a),
        .i_sub_data (rd_data_b),
        .o_total    (o_window_total)
    );

endmodule
